// ----- rtl/substring_last_match_finder_defines.svh -----
// Assertion macros for the substring finder.
`ifndef SUBSTRING_LAST_MATCH_FINDER_DEFINES_SVH
`define SUBSTRING_LAST_MATCH_FINDER_DEFINES_SVH

// same-cycle implication
`define SLMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/slmf_pkg.sv -----
package slmf_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int TEXT_MAX    = 32;
  localparam int QDEPTH      = 4;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 64;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_index_t;

  // one transfer classified by the front end
  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] start;
    logic             last;
  } desc_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ----- rtl/slmf_front.sv -----
module slmf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [slmf_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                take,
  input  logic [slmf_pkg::BYTE_W-1:0]         text_byte,
  input  logic                                record_end,
  output slmf_pkg::desc_t                     desc
);
  import slmf_pkg::*;

  logic [CFG_W-1:0]                 pat_low;
  logic [CFG_W-1:0]                 pat_high;
  logic [LEN_W-1:0]                 pat_len;
  logic [2*CFG_W-1:0]               pat_vec;
  logic [BYTE_W-1:0]                win [PATTERN_MAX];
  logic [BYTE_W-1:0]                nwin [PATTERN_MAX];
  logic [CNT_W-1:0]                 count;
  logic [CNT_W-1:0]                 count_next;
  logic [LEN_W-1:0]                 len_eff;
  logic [LEN_W-1:0]                 idx [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]           hit;
  logic                             counted;
  logic                             eq;

  assign pat_vec = {pat_high, pat_low};
  assign len_eff = (pat_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len;
  assign counted = (count < CNT_W'(TEXT_MAX));
  assign count_next = count + CNT_W'(1);

  always_comb begin
    nwin[0] = text_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      nwin[j] = win[j-1];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx[j] = len_eff - LEN_W'(j) - LEN_W'(1);
      if (LEN_W'(j) < len_eff) begin
        hit[j] = (nwin[j] == pat_vec[idx[j][3:0]*BYTE_W +: BYTE_W]);
      end else begin
        hit[j] = 1'b1;
      end
    end
    eq = &hit;
  end

  always_comb begin
    desc.match = counted && (len_eff != '0) && (count_next >= CNT_W'(len_eff)) && eq;
    desc.start = count_next[POS_W-1:0] - len_eff;
    desc.last  = record_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PAT_LOW:  pat_low  <= cfg_data;
        CFG_PAT_HIGH: pat_high <= cfg_data;
        CFG_PAT_LEN:  pat_len  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int j = 0; j < PATTERN_MAX; j++) win[j] <= '0;
    end else if (take) begin
      if (record_end) begin
        count <= '0;
        for (int j = 0; j < PATTERN_MAX; j++) win[j] <= '0;
      end else if (counted) begin
        count <= count_next;
        for (int j = 0; j < PATTERN_MAX; j++) win[j] <= nwin[j];
      end
    end
  end

endmodule

// ----- rtl/slmf_queue.sv -----
module slmf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  slmf_pkg::desc_t      push_desc,
  input  logic                 pop,
  output slmf_pkg::desc_t      head,
  output slmf_pkg::q_status_t  status
);
  import slmf_pkg::*;

  desc_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head         = mem[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/slmf_back.sv -----
module slmf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  slmf_pkg::desc_t               head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          match_found,
  output logic [slmf_pkg::POS_W-1:0]    match_position
);
  import slmf_pkg::*;

  logic              acc_any;
  logic [POS_W-1:0]  acc_start;

  assign pop = !empty && (!head.last || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_any   <= 1'b0;
      acc_start <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          acc_any   <= 1'b0;
          acc_start <= '0;
        end else if (head.match) begin
          acc_any   <= 1'b1;
          acc_start <= head.start;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      match_found <= acc_any || head.match;
      if (head.match) begin
        match_position <= head.start;
      end else if (acc_any) begin
        match_position <= acc_start;
      end else begin
        match_position <= '0;
      end
    end
  end

endmodule

// ----- rtl/substring_last_match_finder.sv -----
// Streaming substring finder. Text arrives one byte per transfer on the input
// channel (in_valid/in_stall, text_byte, record_end); record_end marks the
// last byte of a record. Each byte is compared against the configured pattern
// of 1 to 16 bytes as it enters, all window positions at once.
// One result per record leaves on the output channel (out_valid/out_stall):
// match_found and the start of the last full match, 0 when none. Bytes beyond
// the 32nd of a record are ignored, but their record_end still closes it.
// Throughput: one byte per cycle while in_stall is low. The front end
// classifies a byte in the cycle it is taken and writes a four-entry queue;
// the back end drains one entry a cycle unless a record-closing entry is
// held by out_stall, and registers out_valid as it pops a record's end.
// When out_stall holds a result, bytes that close no record drain past it;
// the next record-closing byte waits at the head of the queue, and three
// more bytes are taken behind it before in_stall rises.
// The user writes pattern registers (cfg_wr_en/cfg_index/cfg_data) only while
// no transfer is in flight; the block does not enforce it. Synchronous reset
// zeroes the pattern, sets its length to 1, empties window, queue, output.
module substring_last_match_finder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_index,
  input  logic [slmf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [slmf_pkg::BYTE_W-1:0]      text_byte,
  input  logic                             record_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             match_found,
  output logic [slmf_pkg::POS_W-1:0]       match_position
);
  import slmf_pkg::*;

`include "substring_last_match_finder_defines.svh"

  desc_t      front_desc;
  desc_t      head;
  q_status_t  q_stat;
  logic       take;
  logic       pop;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !in_stall;

  slmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .text_byte  (text_byte),
    .record_end (record_end),
    .desc       (front_desc)
  );

  slmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_desc (front_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_stat)
  );

  slmf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (q_stat.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .match_found    (match_found),
    .match_position (match_position)
  );

  `SLMF_ASSERT_NOW(a_pos_zero, out_valid && !match_found, match_position == '0, "position set without match")
  `SLMF_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue overfull")
  `SLMF_ASSERT_NEXT(a_q_inc, take && !pop, q_stat.count == $past(q_stat.count) + QCNT_W'(1), "queue count lost a push")
  `SLMF_ASSERT_NEXT(a_q_dec, pop && !take, q_stat.count == $past(q_stat.count) - QCNT_W'(1), "queue count lost a pop")

endmodule
